// ===== sv/fdr_pkg.sv =====
package fdr_pkg;

  localparam int IDX_W      = 16;
  localparam int COS_W      = 16;
  localparam int CMAG_W     = 16;
  localparam int Q30_W      = 31;
  localparam int SQRT_N     = 31;
  localparam int PROD_W     = 47;
  localparam int RATIO_BITS = 24;
  localparam int RDIV_W     = 48;
  localparam int RMAG_W     = RATIO_BITS + 1;

  localparam logic [CMAG_W-1:0] CMAG_ONE    = 16'h8000;
  localparam logic [31:0]       MIN_COS_SUM = 32'd10738;
  localparam logic [Q30_W-1:0]  ONE_Q30     = 31'h4000_0000;

  typedef struct packed {
    logic [IDX_W-1:0]  no;
    logic [IDX_W-1:0]  ni;
    logic [CMAG_W-1:0] cmag;
  } side_sin_t;

  typedef struct packed {
    logic [IDX_W-1:0]  no;
    logic [IDX_W-1:0]  ni;
    logic [CMAG_W-1:0] cmag;
    logic              tir;
    logic              pz;
  } side_div_t;

  typedef struct packed {
    logic [IDX_W-1:0]  no;
    logic [IDX_W-1:0]  ni;
    logic [CMAG_W-1:0] cmag;
    logic              tir;
  } side_cos_t;

  typedef struct packed {
    logic tir;
    logic zero;
    logic q0;
    logic sz;
  } side_pa_t;

  typedef struct packed {
    logic q0;
    logic sz;
  } side_pe_t;

endpackage

// ===== sv/fdr_sqrt_pipe.sv =====
module fdr_sqrt_pipe #(
  parameter int N  = 31,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [2*N-1:0]  in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [N-1:0]    out_root,
  output logic [SW-1:0]   out_side
);

  logic           vld_r  [N];
  logic [N+1:0]   rem_r  [N];
  logic [N-1:0]   root_r [N];
  logic [2*N-1:0] rad_r  [N];
  logic [SW-1:0]  side_r [N];

  logic           p_vld  [N];
  logic [N+1:0]   p_rem  [N];
  logic [N-1:0]   p_root [N];
  logic [2*N-1:0] p_rad  [N];
  logic [SW-1:0]  p_side [N];

  assign p_vld[0]  = in_vld;
  assign p_rem[0]  = '0;
  assign p_root[0] = '0;
  assign p_rad[0]  = in_rad;
  assign p_side[0] = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N+1:0] rem_s;
    logic [N+1:0] trial;
    logic         ge;

    if (i > 0) begin : g_link
      assign p_vld[i]  = vld_r[i-1];
      assign p_rem[i]  = rem_r[i-1];
      assign p_root[i] = root_r[i-1];
      assign p_rad[i]  = rad_r[i-1];
      assign p_side[i] = side_r[i-1];
    end

    always_comb begin
      rem_s = {p_rem[i][N-1:0], p_rad[i][2*N-1:2*N-2]};
      trial = {p_root[i], 2'b01};
      ge    = (rem_s >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= p_vld[i];
      end
      rem_r[i]  <= ge ? (rem_s - trial) : rem_s;
      root_r[i] <= {p_root[i][N-2:0], ge};
      rad_r[i]  <= {p_rad[i][2*N-3:0], 2'b00};
      side_r[i] <= p_side[i];
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ===== sv/fdr_div_pipe.sv =====
module fdr_div_pipe #(
  parameter int DW = 16,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_den,
  input  logic [QW-1:0] in_bits,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] bits_r [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  logic          p_vld  [QW];
  logic [DW-1:0] p_rem  [QW];
  logic [DW-1:0] p_den  [QW];
  logic [QW-1:0] p_bits [QW];
  logic [QW-1:0] p_quo  [QW];
  logic [SW-1:0] p_side [QW];

  assign p_vld[0]  = in_vld;
  assign p_rem[0]  = in_rem;
  assign p_den[0]  = in_den;
  assign p_bits[0] = in_bits;
  assign p_quo[0]  = '0;
  assign p_side[0] = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    if (i > 0) begin : g_link
      assign p_vld[i]  = vld_r[i-1];
      assign p_rem[i]  = rem_r[i-1];
      assign p_den[i]  = den_r[i-1];
      assign p_bits[i] = bits_r[i-1];
      assign p_quo[i]  = quo_r[i-1];
      assign p_side[i] = side_r[i-1];
    end

    always_comb begin
      t    = {p_rem[i], p_bits[i][QW-1]};
      diff = t - {1'b0, p_den[i]};
      ge   = (t >= {1'b0, p_den[i]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= p_vld[i];
      end
      rem_r[i]  <= ge ? diff[DW-1:0] : t[DW-1:0];
      den_r[i]  <= p_den[i];
      bits_r[i] <= {p_bits[i][QW-2:0], 1'b0};
      quo_r[i]  <= {p_quo[i][QW-2:0], ge};
      side_r[i] <= p_side[i];
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

// ===== sv/fresnel_dielectric_reflectance.sv =====
// Channel   Ports                                         Handshake
// input     in_index_outer, in_index_inner, in_cos_incident  start && !busy
// result    out_reflectance, out_total_reflection          out_strobe, one cycle
//
// One transaction is taken every cycle; busy stays low. Each result is
// computed by the registered stages, the two bit-per-stage square root
// pipelines and the three bit-per-stage divider pipelines.
// Reset clears only the valid bits of the pipeline and the total
// reflection flag. The receiver cannot stall, so the pipeline never holds.
module fresnel_dielectric_reflectance #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [fdr_pkg::IDX_W-1:0]       in_index_outer,
  input  logic [fdr_pkg::IDX_W-1:0]       in_index_inner,
  input  logic signed [fdr_pkg::COS_W-1:0] in_cos_incident,
  output logic                            out_strobe,
  output logic [OUT_FRAC_BITS:0]          out_reflectance,
  output logic                            out_total_reflection
);
  import fdr_pkg::*;

  localparam int SH = 2 * RATIO_BITS + 1 - OUT_FRAC_BITS;
  localparam logic [51:0] RND = 52'(1) << (SH - 1);
  localparam logic [OUT_FRAC_BITS:0] ONE_OUT = {1'b1, {OUT_FRAC_BITS{1'b0}}};

  assign busy = 1'b0;

  // Stage 1: absolute cosine, clamped to one.
  logic [15:0] raw;
  logic [CMAG_W-1:0] cmag_c;
  logic v1_r;
  logic [IDX_W-1:0] no1_r, ni1_r;
  logic [CMAG_W-1:0] cmag1_r;

  always_comb begin
    raw    = in_cos_incident;
    cmag_c = raw[15] ? 16'(17'h10000 - {1'b0, raw}) : raw;
    if (cmag_c > CMAG_ONE) begin
      cmag_c = CMAG_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    no1_r   <= in_index_outer;
    ni1_r   <= in_index_inner;
    cmag1_r <= cmag_c;
  end

  // Stage 2: radicand for the incident sine.
  logic v2_r;
  logic [61:0] rad2_r;
  side_sin_t side2_r;
  logic [31:0] csq;

  assign csq = 32'(cmag1_r) * 32'(cmag1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    rad2_r  <= {(32'h4000_0000 - csq), 30'b0};
    side2_r <= '{no: no1_r, ni: ni1_r, cmag: cmag1_r};
  end

  logic v3;
  logic [Q30_W-1:0] so3;
  logic [$bits(side_sin_t)-1:0] side3_raw;
  side_sin_t side3;

  fdr_sqrt_pipe #(.N(SQRT_N), .SW($bits(side_sin_t))) u_sqrt_sin (
    .clk, .rst_n,
    .in_vld(v2_r), .in_rad(rad2_r), .in_side(side2_r),
    .out_vld(v3), .out_root(so3), .out_side(side3_raw)
  );
  assign side3 = side3_raw;

  // Stage 4: sine times outer index.
  logic v4_r;
  logic [PROD_W-1:0] prod4_r;
  side_sin_t side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3;
    end
    prod4_r <= PROD_W'(so3) * PROD_W'(side3.no);
    side4_r <= side3;
  end

  // Stage 5: total internal reflection test and divider setup.
  logic v5_r;
  logic [PROD_W-1:0] prod5_r;
  side_div_t side5_r;
  logic [PROD_W-1:0] lim;

  assign lim = PROD_W'({side4_r.ni, 30'b0}) + PROD_W'(side4_r.ni);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    prod5_r <= prod4_r;
    side5_r <= '{no: side4_r.no, ni: side4_r.ni, cmag: side4_r.cmag,
                 tir: (prod4_r != '0) && (prod4_r >= lim),
                 pz: (prod4_r == '0)};
  end

  logic v6;
  logic [Q30_W-1:0] q6;
  logic [$bits(side_div_t)-1:0] side6_raw;
  side_div_t side6;

  fdr_div_pipe #(.DW(IDX_W), .QW(Q30_W), .SW($bits(side_div_t))) u_div_sin (
    .clk, .rst_n,
    .in_vld(v5_r), .in_rem(prod5_r[PROD_W-1:Q30_W]), .in_den(side5_r.ni),
    .in_bits(prod5_r[Q30_W-1:0]), .in_side(side5_r),
    .out_vld(v6), .out_quo(q6), .out_side(side6_raw)
  );
  assign side6 = side6_raw;

  // Stage 7: square of the transmitted sine.
  logic v7_r;
  logic [61:0] stsq7_r;
  side_cos_t side7_r;
  logic [Q30_W-1:0] st6;

  assign st6 = (side6.pz || side6.tir) ? '0 : q6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6;
    end
    stsq7_r <= 62'(st6) * 62'(st6);
    side7_r <= '{no: side6.no, ni: side6.ni, cmag: side6.cmag, tir: side6.tir};
  end

  // Stage 8: radicand for the transmitted cosine.
  logic v8_r;
  logic [61:0] rad8_r;
  side_cos_t side8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
    rad8_r  <= 62'h1000_0000_0000_0000 - stsq7_r;
    side8_r <= side7_r;
  end

  logic v9;
  logic [Q30_W-1:0] ct9;
  logic [$bits(side_cos_t)-1:0] side9_raw;
  side_cos_t side9;

  fdr_sqrt_pipe #(.N(SQRT_N), .SW($bits(side_cos_t))) u_sqrt_cos (
    .clk, .rst_n,
    .in_vld(v8_r), .in_rad(rad8_r), .in_side(side8_r),
    .out_vld(v9), .out_root(ct9), .out_side(side9_raw)
  );
  assign side9 = side9_raw;

  // Stage 10: grazing test and the four cross products.
  logic v10_r, tir10_r, zero10_r;
  logic [PROD_W-1:0] a10_r, b10_r, c10_r, d10_r;
  logic [Q30_W-1:0] co9;
  logic [31:0] csum9;

  assign co9   = {side9.cmag, 15'b0};
  assign csum9 = {1'b0, co9} + {1'b0, ct9};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else begin
      v10_r <= v9;
    end
    tir10_r  <= side9.tir;
    zero10_r <= (csum9 < MIN_COS_SUM);
    a10_r    <= PROD_W'(side9.ni) * PROD_W'(co9);
    b10_r    <= PROD_W'(side9.no) * PROD_W'(ct9);
    c10_r    <= PROD_W'(side9.no) * PROD_W'(co9);
    d10_r    <= PROD_W'(side9.ni) * PROD_W'(ct9);
  end

  // Stage 11: sums, differences and leading quotient bits.
  logic v11_r;
  logic [RDIV_W-1:0] rem_pa11_r, rem_pe11_r, s_pa11_r, s_pe11_r;
  side_pa_t side_pa11_r;
  side_pe_t side_pe11_r;
  logic [RDIV_W-1:0] s_pa, s_pe, n_pa, n_pe;
  logic q0_pa, q0_pe;

  always_comb begin
    s_pa  = {1'b0, a10_r} + {1'b0, b10_r};
    s_pe  = {1'b0, c10_r} + {1'b0, d10_r};
    n_pa  = (a10_r > b10_r) ? RDIV_W'(a10_r - b10_r) : RDIV_W'(b10_r - a10_r);
    n_pe  = (c10_r > d10_r) ? RDIV_W'(c10_r - d10_r) : RDIV_W'(d10_r - c10_r);
    q0_pa = (n_pa >= s_pa);
    q0_pe = (n_pe >= s_pe);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else begin
      v11_r <= v10_r;
    end
    s_pa11_r    <= s_pa;
    s_pe11_r    <= s_pe;
    rem_pa11_r  <= q0_pa ? (n_pa - s_pa) : n_pa;
    rem_pe11_r  <= q0_pe ? (n_pe - s_pe) : n_pe;
    side_pa11_r <= '{tir: tir10_r, zero: zero10_r, q0: q0_pa, sz: (s_pa == '0)};
    side_pe11_r <= '{q0: q0_pe, sz: (s_pe == '0)};
  end

  logic v_pa, v_pe;
  logic [RATIO_BITS-1:0] q_pa, q_pe;
  logic [$bits(side_pa_t)-1:0] side_pa_raw;
  logic [$bits(side_pe_t)-1:0] side_pe_raw;
  side_pa_t side_pa;
  side_pe_t side_pe;

  fdr_div_pipe #(.DW(RDIV_W), .QW(RATIO_BITS), .SW($bits(side_pa_t))) u_div_par (
    .clk, .rst_n,
    .in_vld(v11_r), .in_rem(rem_pa11_r), .in_den(s_pa11_r),
    .in_bits('0), .in_side(side_pa11_r),
    .out_vld(v_pa), .out_quo(q_pa), .out_side(side_pa_raw)
  );

  fdr_div_pipe #(.DW(RDIV_W), .QW(RATIO_BITS), .SW($bits(side_pe_t))) u_div_perp (
    .clk, .rst_n,
    .in_vld(v11_r), .in_rem(rem_pe11_r), .in_den(s_pe11_r),
    .in_bits('0), .in_side(side_pe11_r),
    .out_vld(v_pe), .out_quo(q_pe), .out_side(side_pe_raw)
  );
  assign side_pa = side_pa_raw;
  assign side_pe = side_pe_raw;

  // Stage 12: squared ratio magnitudes.
  logic v12_r, tir12_r, zero12_r;
  logic [2*RMAG_W-1:0] sq_pa12_r, sq_pe12_r;
  logic [RMAG_W-1:0] r_pa, r_pe;

  assign r_pa = side_pa.sz ? {1'b1, {RATIO_BITS{1'b0}}} : {side_pa.q0, q_pa};
  assign r_pe = side_pe.sz ? {1'b1, {RATIO_BITS{1'b0}}} : {side_pe.q0, q_pe};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
    end else begin
      v12_r <= v_pa && v_pe;
    end
    tir12_r   <= side_pa.tir;
    zero12_r  <= side_pa.zero;
    sq_pa12_r <= (2*RMAG_W)'(r_pa) * (2*RMAG_W)'(r_pa);
    sq_pe12_r <= (2*RMAG_W)'(r_pe) * (2*RMAG_W)'(r_pe);
  end

  // Stage 13: mean, rounding, saturation and special cases.
  logic [51:0] sum_rnd, refl_full;
  logic [OUT_FRAC_BITS:0] refl_c;
  logic strobe_r, tr_r;
  logic [OUT_FRAC_BITS:0] refl_r;

  always_comb begin
    sum_rnd   = 52'(sq_pa12_r) + 52'(sq_pe12_r) + RND;
    refl_full = sum_rnd >> SH;
    if (tir12_r) begin
      refl_c = ONE_OUT;
    end else if (zero12_r) begin
      refl_c = '0;
    end else if (refl_full > 52'(ONE_OUT)) begin
      refl_c = ONE_OUT;
    end else begin
      refl_c = refl_full[OUT_FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      tr_r     <= 1'b0;
    end else begin
      strobe_r <= v12_r;
      tr_r     <= v12_r && tir12_r;
    end
    refl_r <= refl_c;
  end

  assign out_strobe           = strobe_r;
  assign out_reflectance      = refl_r;
  assign out_total_reflection = tr_r;

  a_tr_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_total_reflection |-> out_strobe)
    else $error("total reflection flag without a result");

  a_tr_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_total_reflection |-> (out_reflectance == ONE_OUT))
    else $error("total reflection without reflectance one");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_reflectance <= ONE_OUT))
    else $error("reflectance above one");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v12_r |=> out_strobe)
    else $error("result lost at the output register");

endmodule
